// ===== design/assert_macros.svh =====
// Assertion macros shared by the life generation engine modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== design/gle_pkg.sv =====
// Package of the life generation engine: sizes, command codes, state and
// interface types, and the B3/S23 cell rule. Depends on nothing.
package gle_pkg;

    // Grid storage size.
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    // Widths derived from the storage size.
    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int COL_AW = $clog2(MAX_COLS);
    localparam int CNT_W  = $clog2(MAX_ROWS + 2);

    // Field widths of the ports.
    localparam int CMD_W    = 2;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 6;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;

    // Command codes; the fourth code does nothing.
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 1'd1;
    localparam logic [CFG_W-1:0]     ROWS_USED_RST = 7'd64;
    localparam logic [CFG_W-1:0]     COLS_USED_RST = 7'd64;

    // Neighbor counts of the rule.
    localparam logic [3:0] LIFE_KEEP = 4'd2;
    localparam logic [3:0] LIFE_BORN = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CELL,
        ST_STEP,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic cell_rd;
        logic cell_update;
        logic step_run;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic step_last;
    } dp_status_t;

    // B3/S23: born with three neighbors, survives with two or three.
    function automatic logic life_next(logic [3:0] count, logic alive);
        return (count == LIFE_BORN) || ((count == LIFE_KEEP) && alive);
    endfunction

endpackage

// ===== design/life_generation_engine.sv =====
// Top level of the life generation engine: controller and datapath.
// Depends on gle_pkg, gle_ctrl and gle_datapath.

// Holds a grid of MAX_ROWS by MAX_COLS one-bit cells (all dead after reset) and
// runs Conway's Life, rule B3/S23, over the window set by rows_used and
// cols_used; after a step every cell outside the window interior is dead.
// Each accepted item gives exactly one result item. A write or read of one
// cell passes through the ST_CELL and ST_DONE states to the result register,
// as the registered read of the row-wide grid memory comes before the
// read-modify-write. In a step the memory is swept one row per cycle, and a
// three-row window evaluates all columns of a row at once, writing each new
// row back in place once the row below it has been read. An unused command
// goes straight to ST_DONE. The next item is accepted in the cycle after the
// previous result is loaded into the output register, even while that result
// still waits to be taken. Reset needs no clearing pass: per-row valid bits
// make unwritten rows read as dead.
module life_generation_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [gle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gle_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gle_pkg::CMD_W-1:0]     s_cmd,
    input  logic [gle_pkg::ROW_W-1:0]     s_row,
    input  logic [gle_pkg::COL_W-1:0]     s_col,
    input  logic                          s_cell_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gle_pkg::CMD_W-1:0]     m_done_cmd,
    output logic                          m_cell_out
);

    gle_pkg::ctrl_cmd_t  ctrl_cmd;
    gle_pkg::dp_status_t dp_status;

    // Command sequencing.
    gle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (dp_status),
        .cmd     (ctrl_cmd)
    );

    // Grid storage and rule evaluation.
    gle_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_cmd      (s_cmd),
        .s_row      (s_row),
        .s_col      (s_col),
        .s_cell_in  (s_cell_in),
        .m_done_cmd (m_done_cmd),
        .m_cell_out (m_cell_out),
        .cmd        (ctrl_cmd),
        .status     (dp_status)
    );

endmodule

// ===== design/gle_ctrl.sv =====
// Controller of the life generation engine: command sequencing and the
// output valid flag. Depends on gle_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gle_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [gle_pkg::CMD_W-1:0] s_cmd,
    output logic                      m_valid,
    input  logic                      m_ready,
    input  gle_pkg::dp_status_t       status,
    output gle_pkg::ctrl_cmd_t        cmd
);

    gle_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            slot_free;

    // The output register can take a new item when empty or being drained.
    assign slot_free = !out_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gle_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == gle_pkg::CMD_WRITE || s_cmd == gle_pkg::CMD_READ) begin
                        state_next = gle_pkg::ST_CELL;
                    end else if (s_cmd == gle_pkg::CMD_STEP) begin
                        state_next = gle_pkg::ST_STEP;
                    end else begin
                        state_next = gle_pkg::ST_DONE;
                    end
                end
            end
            gle_pkg::ST_CELL: state_next = gle_pkg::ST_DONE;
            gle_pkg::ST_STEP: begin
                if (status.step_last) begin
                    state_next = gle_pkg::ST_DONE;
                end
            end
            gle_pkg::ST_DONE: begin
                if (slot_free) begin
                    state_next = gle_pkg::ST_IDLE;
                end
            end
            default: state_next = gle_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        s_ready         = (state_reg == gle_pkg::ST_IDLE);
        cmd.capture     = s_valid && (state_reg == gle_pkg::ST_IDLE);
        cmd.cell_rd     = cmd.capture &&
                          (s_cmd == gle_pkg::CMD_WRITE || s_cmd == gle_pkg::CMD_READ);
        cmd.cell_update = (state_reg == gle_pkg::ST_CELL);
        cmd.step_run    = (state_reg == gle_pkg::ST_STEP);
        cmd.out_load    = (state_reg == gle_pkg::ST_DONE) && slot_free;
    end

    // Output valid: set on load, cleared when the item is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gle_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    `ASSERT_IMPLY(a_valid_from_done, aclk, aresetn, $rose(out_valid_reg),
                  $past(state_reg) == gle_pkg::ST_DONE)
    `ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_valid && s_ready,
                 state_reg != gle_pkg::ST_IDLE)
    `ASSERT_IMPLY(a_step_last_in_step, aclk, aresetn, status.step_last && cmd.step_run,
                  state_next == gle_pkg::ST_DONE)

endmodule

// ===== design/gle_datapath.sv =====
// Datapath of the life generation engine: configuration registers, the
// row-wide grid memory with row valid bits, the three-row window and the
// per-row rule evaluation. Depends on gle_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gle_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [gle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gle_pkg::CFG_W-1:0]     cfg_data,
    input  logic [gle_pkg::CMD_W-1:0]     s_cmd,
    input  logic [gle_pkg::ROW_W-1:0]     s_row,
    input  logic [gle_pkg::COL_W-1:0]     s_col,
    input  logic                          s_cell_in,
    output logic [gle_pkg::CMD_W-1:0]     m_done_cmd,
    output logic                          m_cell_out,
    input  gle_pkg::ctrl_cmd_t            cmd,
    output gle_pkg::dp_status_t           status
);

    localparam int MR = gle_pkg::MAX_ROWS;
    localparam int MC = gle_pkg::MAX_COLS;

    // Configuration registers.
    logic [gle_pkg::CFG_W-1:0] rows_used_reg, cols_used_reg;

    // Captured item.
    logic [gle_pkg::CMD_W-1:0] cmd_reg;
    logic [gle_pkg::ROW_W-1:0] row_reg;
    logic [gle_pkg::COL_W-1:0] col_reg;
    logic                      val_reg;
    logic                      inside_reg;
    logic                      result_bit_reg;
    logic                      in_grid;

    // Grid memory, one word per row, and its valid bits.
    logic [MC-1:0]           grid_mem [MR];
    logic [MR-1:0]           row_valid_reg;
    logic [MC-1:0]           rdata_reg;
    logic                    rvalid_reg;
    logic                    mem_re, mem_we;
    logic [gle_pkg::ROW_AW-1:0] rd_addr, wr_addr;
    logic [MC-1:0]           wr_data;
    logic [MC-1:0]           mem_row;

    // Step sequencing and the row window.
    logic [gle_pkg::CNT_W-1:0] cnt_reg;
    logic [gle_pkg::CNT_W-1:0] wr_row;
    logic [MC-1:0]             win_above_reg, win_mid_reg;
    logic                      step_re, step_we, step_shift;
    logic                      row_interior;
    logic [MC-1:0]             col_mask, life_row, cell_row;
    logic [MC+1:0]             up_p, mid_p, dn_p;

    // Output payload.
    logic [gle_pkg::CMD_W-1:0] done_cmd_reg;
    logic                      cell_out_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_used_reg <= gle_pkg::ROWS_USED_RST;
            cols_used_reg <= gle_pkg::COLS_USED_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gle_pkg::CFG_ROWS_USED: rows_used_reg <= cfg_data;
                gle_pkg::CFG_COLS_USED: cols_used_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_grid = (32'(s_row) < 32'(MR)) && (32'(s_col) < 32'(MC));

    // The row read last cycle, with never-written rows reading as dead.
    assign mem_row = rvalid_reg ? rdata_reg : '0;

    // Step timing: row c is read at count c, row c-2 is written at count c.
    assign step_re    = cmd.step_run && (cnt_reg < gle_pkg::CNT_W'(MR));
    assign step_shift = cmd.step_run && (cnt_reg != '0);
    assign step_we    = cmd.step_run && (cnt_reg >= gle_pkg::CNT_W'(2));
    assign wr_row     = cnt_reg - gle_pkg::CNT_W'(2);
    assign status.step_last = (cnt_reg == gle_pkg::CNT_W'(MR + 1));

    // Row of the window that is being written lies strictly inside.
    assign row_interior = (wr_row != '0) &&
                          (32'(wr_row) + 32'd1 < 32'(MR)) &&
                          (32'(wr_row) + 32'd1 < 32'(rows_used_reg));

    // Neighbor rows padded with a dead column on each side.
    assign up_p  = {1'b0, win_above_reg, 1'b0};
    assign mid_p = {1'b0, win_mid_reg, 1'b0};
    assign dn_p  = {1'b0, mem_row, 1'b0};

    // Rule evaluation for every column of the row in parallel.
    for (genvar i = 0; i < MC; i++) begin : g_col
        logic [3:0] count;
        assign count = 4'(up_p[i]) + 4'(up_p[i+1]) + 4'(up_p[i+2]) +
                       4'(mid_p[i]) + 4'(mid_p[i+2]) +
                       4'(dn_p[i]) + 4'(dn_p[i+1]) + 4'(dn_p[i+2]);
        assign col_mask[i] = (i >= 1) && (i + 1 < MC) &&
                             (32'(i + 1) < 32'(cols_used_reg));
        assign life_row[i] = gle_pkg::life_next(count, win_mid_reg[i]);
    end

    // Single cell update merged into the row just read.
    always_comb begin
        cell_row = mem_row;
        cell_row[gle_pkg::COL_AW'(col_reg)] = val_reg;
    end

    // Memory port selection.
    always_comb begin
        mem_re  = cmd.cell_rd || step_re;
        rd_addr = cmd.step_run ? cnt_reg[gle_pkg::ROW_AW-1:0] : gle_pkg::ROW_AW'(s_row);
        mem_we  = 1'b0;
        wr_addr = gle_pkg::ROW_AW'(row_reg);
        wr_data = cell_row;
        priority if (step_we) begin
            mem_we  = 1'b1;
            wr_addr = wr_row[gle_pkg::ROW_AW-1:0];
            wr_data = row_interior ? (life_row & col_mask) : '0;
        end else if (cmd.cell_update && inside_reg && cmd_reg == gle_pkg::CMD_WRITE) begin
            mem_we = 1'b1;
        end else begin
            mem_we = 1'b0;
        end
    end

    // Grid memory with registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            rdata_reg <= grid_mem[rd_addr];
        end
    end

    // Row valid bits and the read-valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end else begin
            if (mem_we) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            rvalid_reg <= mem_re && row_valid_reg[rd_addr];
        end
    end

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.capture) begin
            cnt_reg <= '0;
        end else if (cmd.step_run) begin
            cnt_reg <= cnt_reg + gle_pkg::CNT_W'(1);
        end
    end

    // Item capture, window shift and result bit.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg        <= s_cmd;
            row_reg        <= s_row;
            col_reg        <= s_col;
            val_reg        <= s_cell_in;
            inside_reg     <= in_grid;
            result_bit_reg <= 1'b0;
            win_above_reg  <= '0;
            win_mid_reg    <= '0;
        end else begin
            if (step_shift) begin
                win_above_reg <= win_mid_reg;
                win_mid_reg   <= mem_row;
            end
            if (cmd.cell_update) begin
                result_bit_reg <= inside_reg && (cmd_reg == gle_pkg::CMD_READ) &&
                                  mem_row[gle_pkg::COL_AW'(col_reg)];
            end
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            done_cmd_reg <= cmd_reg;
            cell_out_reg <= result_bit_reg;
        end
    end

    assign m_done_cmd = done_cmd_reg;
    assign m_cell_out = cell_out_reg;

    `ASSERT_IMPLY(a_step_write_behind_read, aclk, aresetn, step_we && step_re,
                  wr_row < cnt_reg)
    `ASSERT_NEXT(a_step_fills_grid, aclk, aresetn, cmd.step_run && status.step_last,
                 &row_valid_reg)
    `ASSERT_IMPLY(a_cell_out_only_read, aclk, aresetn,
                  cmd.out_load && cmd_reg != gle_pkg::CMD_READ, !result_bit_reg)

endmodule
